FILE: sv/lom_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lom_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_LIMIT    = 3'd1,
        ST_HELD     = 3'd2,
        ST_ORDER    = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_MISMATCH = 3'd5
    } t_status;

    // item function codes
    localparam logic [1:0] FN_CHECK   = 2'd0;
    localparam logic [1:0] FN_PUSH    = 2'd1;
    localparam logic [1:0] FN_RELEASE = 2'd2;

    localparam int unsigned CFG_BITS   = 5;
    localparam int unsigned COUNT_BITS = 5;
    localparam logic [CFG_BITS-1:0] MAX_HELD_RST = 5'd16;

    // memory port controls
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

FILE: sv/lom_stack_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module lom_stack_mem #(
    parameter int unsigned WIDTH = 49,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  wire logic              i_clk,
    input  wire lom_pkg::t_mem_ctl i_ctl,
    input  wire logic [AW-1:0]     i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [AW-1:0]     i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: sv/lom_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module lom_seq #(
    parameter int unsigned STACK_DEPTH = 16,
    parameter int unsigned ID_BITS     = 32,
    parameter int unsigned RANK_BITS   = 16,
    parameter int unsigned AW          = 4,
    parameter int unsigned DW          = 5,
    parameter int unsigned EW          = ID_BITS + RANK_BITS + 1
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [1:0]                        i_func,
    input  wire logic [ID_BITS-1:0]                i_lock_id,
    input  wire logic [RANK_BITS-1:0]              i_lock_rank,
    input  wire logic                              i_hold_mode,
    input  wire logic [lom_pkg::CFG_BITS-1:0]      i_max_held,
    output logic                                   o_busy,
    output logic                                   o_done,
    output logic [2:0]                             o_status,
    output logic [lom_pkg::COUNT_BITS-1:0]         o_held_count,
    output lom_pkg::t_mem_ctl                      o_mem_ctl,
    output logic [AW-1:0]                          o_wr_addr,
    output logic [EW-1:0]                          o_wr_data,
    output logic [AW-1:0]                          o_rd_addr,
    input  wire logic [EW-1:0]                     i_rd_data
);

    localparam int unsigned CW = (DW > lom_pkg::CFG_BITS) ? DW : lom_pkg::CFG_BITS;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_REL  = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic [DW-1:0]          r_depth, n_depth;
    logic [AW-1:0]          r_idx, n_idx;
    logic [ID_BITS-1:0]     r_id;
    logic [RANK_BITS-1:0]   r_rank;
    logic                   r_mode;
    logic                   r_done, n_done;
    lom_pkg::t_status       r_status, n_status;

    logic                   accept;
    logic                   limit_hit;
    logic                   full;
    logic [ID_BITS-1:0]     ent_id;
    logic [RANK_BITS-1:0]   ent_rank;
    logic                   ent_mode;
    logic [DW-1:0]          idx_next;

    assign accept    = i_start && (r_state == S_IDLE);
    assign full      = (r_depth == DW'(STACK_DEPTH));
    assign limit_hit = (CW'(r_depth) >= CW'(i_max_held)) || full;

    assign ent_id   = i_rd_data[EW-1 -: ID_BITS];
    assign ent_rank = i_rd_data[RANK_BITS:1];
    assign ent_mode = i_rd_data[0];
    assign idx_next = DW'(r_idx) + DW'(1);

    always_comb begin
        n_state   = r_state;
        n_depth   = r_depth;
        n_idx     = r_idx;
        n_done    = 1'b0;
        n_status  = r_status;
        o_mem_ctl = '0;
        o_wr_addr = r_depth[AW-1:0];
        o_wr_data = {i_lock_id, i_lock_rank, i_hold_mode};
        o_rd_addr = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_func)
                        lom_pkg::FN_CHECK: begin
                            if (limit_hit) begin
                                n_done   = 1'b1;
                                n_status = lom_pkg::ST_LIMIT;
                            end else if (r_depth == '0) begin
                                n_done   = 1'b1;
                                n_status = lom_pkg::ST_OK;
                            end else begin
                                o_mem_ctl.rd_en = 1'b1;
                                o_rd_addr       = '0;
                                n_idx           = '0;
                                n_state         = S_WALK;
                            end
                        end
                        lom_pkg::FN_PUSH: begin
                            n_done = 1'b1;
                            if (full) begin
                                n_status = lom_pkg::ST_LIMIT;
                            end else begin
                                o_mem_ctl.wr_en = 1'b1;
                                n_depth         = r_depth + DW'(1);
                                n_status        = lom_pkg::ST_OK;
                            end
                        end
                        lom_pkg::FN_RELEASE: begin
                            if (r_depth == '0) begin
                                n_done   = 1'b1;
                                n_status = lom_pkg::ST_EMPTY;
                            end else begin
                                o_mem_ctl.rd_en = 1'b1;
                                o_rd_addr       = AW'(r_depth - DW'(1));
                                n_state         = S_REL;
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = lom_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_WALK: begin
                // entry r_idx is on the read data, the next one is fetched behind it
                if (ent_id == r_id) begin
                    n_done   = 1'b1;
                    n_status = lom_pkg::ST_HELD;
                    n_state  = S_IDLE;
                end else if ((r_rank != '0) && (ent_rank != '0) && (r_rank <= ent_rank)) begin
                    n_done   = 1'b1;
                    n_status = lom_pkg::ST_ORDER;
                    n_state  = S_IDLE;
                end else if (idx_next < r_depth) begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_rd_addr       = idx_next[AW-1:0];
                    n_idx           = idx_next[AW-1:0];
                end else begin
                    n_done   = 1'b1;
                    n_status = lom_pkg::ST_OK;
                    n_state  = S_IDLE;
                end
            end
            S_REL: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                if ((ent_id == r_id) && (ent_mode == r_mode)) begin
                    n_depth  = r_depth - DW'(1);
                    n_status = lom_pkg::ST_OK;
                end else begin
                    n_status = lom_pkg::ST_MISMATCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_status <= n_status;
        if (accept) begin
            r_id   <= i_lock_id;
            r_rank <= i_lock_rank;
            r_mode <= i_hold_mode;
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_held_count = lom_pkg::COUNT_BITS'(r_depth);

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(STACK_DEPTH))
        else $error("stack depth above capacity");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (DW'(r_idx) < r_depth))
        else $error("walk index beyond held entries");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe while still working");

    a_rel_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REL) |=> r_done)
        else $error("release gave no result");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_func == lom_pkg::FN_PUSH) && !full)
            |=> (r_depth == $past(r_depth) + DW'(1)))
        else $error("push did not grow the stack");
`endif

endmodule

`default_nettype wire

FILE: sv/lock_order_monitor.sv
// lock order monitor for one execution context. send an item by raising
// i_start while o_busy is low; func selects check acquire (no state change),
// record acquire (push) or release (match identity and mode of the top entry,
// then pop). every item gives exactly one result: o_done is high for a single
// cycle with o_status and o_held_count, and the receiver cannot stall it, so
// it must take the result in that cycle. push, func 3 and checks that end at
// once (limit reached, nothing held) strobe o_done the cycle after the start
// and leave o_busy low. a release reads the top entry from the stack memory
// in state S_REL, with o_busy high, and then strobes. a check walks the held
// entries from the bottom, one memory read and compare per cycle, and stops
// at the first failure; o_busy stays high during the walk. a full stack is
// refused by the limit test, so a walk sees at most STACK_DEPTH-1 entries.
// the max_held register is written through i_cfg_wdata with i_cfg_we; the
// user must write it only while no item is in flight, as the block itself
// does not enforce this. it resets to 16; the full test caps its effect at
// STACK_DEPTH. no clearing pass is needed after reset: only entries below
// the stack depth are ever read.
`timescale 1ns / 1ps
`default_nettype none

module lock_order_monitor #(
    parameter int unsigned STACK_DEPTH = 16,
    parameter int unsigned ID_BITS     = 32,
    parameter int unsigned RANK_BITS   = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // item channel
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire logic [1:0]                   i_func,
    input  wire logic [ID_BITS-1:0]           i_lock_id,
    input  wire logic [RANK_BITS-1:0]         i_lock_rank,
    input  wire logic                         i_hold_mode,
    // result strobe
    output logic                              o_done,
    output logic [2:0]                        o_status,
    output logic [lom_pkg::COUNT_BITS-1:0]    o_held_count,
    // configuration
    input  wire logic                         i_cfg_we,
    input  wire logic [lom_pkg::CFG_BITS-1:0] i_cfg_wdata
);

    // stack address, depth counter (holds STACK_DEPTH itself) and entry widths
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned EW = ID_BITS + RANK_BITS + 1;

    // max_held register, reset to sixteen
    logic [lom_pkg::CFG_BITS-1:0] r_max_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_held <= lom_pkg::MAX_HELD_RST;
        end else if (i_cfg_we) begin
            r_max_held <= i_cfg_wdata;
        end
    end

    // memory port between sequencer and stack memory
    lom_pkg::t_mem_ctl mem_ctl;
    logic [AW-1:0]     wr_addr;
    logic [EW-1:0]     wr_data;
    logic [AW-1:0]     rd_addr;
    logic [EW-1:0]     rd_data;

    // entry layout: {identity, rank, mode}
    lom_stack_mem #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // sequencer: depth counter, walk over held entries, result register
    lom_seq #(
        .STACK_DEPTH (STACK_DEPTH),
        .ID_BITS     (ID_BITS),
        .RANK_BITS   (RANK_BITS),
        .AW          (AW),
        .DW          (DW),
        .EW          (EW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_func       (i_func),
        .i_lock_id    (i_lock_id),
        .i_lock_rank  (i_lock_rank),
        .i_hold_mode  (i_hold_mode),
        .i_max_held   (r_max_held),
        .o_busy       (o_busy),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_held_count (o_held_count),
        .o_mem_ctl    (mem_ctl),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data)
    );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // block sizes, kept at the defaults of the block
    localparam int unsigned STACK_N = 16;
    localparam int unsigned ID_W    = 32;
    localparam int unsigned RANK_W  = 16;

    // func 3 is unused by the block: it must answer ok with the current depth
    localparam logic [1:0] FN_IDLE = 2'd3;

    // cycles with nothing accepted or answered before the run is called hung
    localparam int unsigned WATCH_LIMIT = 2000;
    localparam int unsigned CHUNKS      = 8;
    localparam int unsigned CHUNK_ITEMS = 200;

    // one lock request as it goes into the block
    typedef struct packed {
        logic [1:0]        fn;
        logic [ID_W-1:0]   id;
        logic [RANK_W-1:0] rank;
        logic              mode;
    } t_lock_item;

    // one answer as the block should give it
    typedef struct packed {
        lom_pkg::t_status                st;
        logic [lom_pkg::COUNT_BITS-1:0] cnt;
    } t_lock_answer;

    // shadow of the lock stack: works out the answer for every accepted item
    // and holds the answers still owed by the block
    class lock_stack_board;
        logic [ID_W-1:0]              ids   [STACK_N];
        logic [RANK_W-1:0]            ranks [STACK_N];
        logic                         modes [STACK_N];
        int unsigned                  depth;
        logic [lom_pkg::CFG_BITS-1:0] limit;
        t_lock_answer                 owed [$];

        function new();
            depth = 0;
            limit = lom_pkg::MAX_HELD_RST;
        endfunction

        function void set_limit(logic [lom_pkg::CFG_BITS-1:0] val);
            limit = val;
        endfunction

        function int unsigned pending();
            return owed.size();
        endfunction

        // may this lock be taken now: limit first, then bottom-up walk,
        // identity before rank at each entry
        function lom_pkg::t_status may_take(logic [ID_W-1:0] id, logic [RANK_W-1:0] rank);
            if (depth >= limit || depth >= STACK_N)
                return lom_pkg::ST_LIMIT;
            for (int unsigned i = 0; i < depth; i++) begin
                if (ids[i] == id)
                    return lom_pkg::ST_HELD;
                if (rank != 0 && ranks[i] != 0 && rank <= ranks[i])
                    return lom_pkg::ST_ORDER;
            end
            return lom_pkg::ST_OK;
        endfunction

        function void note_item(t_lock_item it);
            lom_pkg::t_status st;
            st = lom_pkg::ST_OK;
            case (it.fn)
                lom_pkg::FN_CHECK: begin
                    st = may_take(it.id, it.rank);
                end
                lom_pkg::FN_PUSH: begin
                    // push ignores the limit register, only a full stack refuses
                    if (depth >= STACK_N) begin
                        st = lom_pkg::ST_LIMIT;
                    end else begin
                        ids[depth]   = it.id;
                        ranks[depth] = it.rank;
                        modes[depth] = it.mode;
                        depth++;
                    end
                end
                lom_pkg::FN_RELEASE: begin
                    if (depth == 0)
                        st = lom_pkg::ST_EMPTY;
                    else if (ids[depth-1] != it.id || modes[depth-1] != it.mode)
                        st = lom_pkg::ST_MISMATCH;
                    else
                        depth--;
                end
                default: ;
            endcase
            owed.push_back('{st: st, cnt: depth[lom_pkg::COUNT_BITS-1:0]});
        endfunction

        // empty string when the answer is the one owed
        function string check_result(logic [2:0] st, logic [lom_pkg::COUNT_BITS-1:0] cnt);
            t_lock_answer want;
            if (owed.size() == 0)
                return $sformatf("result status %0d count %0d with no item outstanding",
                                 st, cnt);
            want = owed.pop_front();
            if (st !== want.st || cnt !== want.cnt)
                return $sformatf("status %0d want %0d, held count %0d want %0d",
                                 st, want.st, cnt, want.cnt);
            return "";
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_start;
    logic                           o_busy;
    logic [1:0]                     i_func;
    logic [ID_W-1:0]                i_lock_id;
    logic [RANK_W-1:0]              i_lock_rank;
    logic                           i_hold_mode;
    logic                           o_done;
    logic [2:0]                     o_status;
    logic [lom_pkg::COUNT_BITS-1:0] o_held_count;
    logic                           i_cfg_we;
    logic [lom_pkg::CFG_BITS-1:0]   i_cfg_wdata;

    lock_stack_board board;
    int unsigned     err_count   = 0;
    int unsigned     idle_cycles = 0;
    int unsigned     idle_pct    = 0;
    string           verdict;

    // what the stimulus believes is held, used only to shape new items
    logic [ID_W-1:0]   gen_ids   [$];
    logic [RANK_W-1:0] gen_ranks [$];
    logic              gen_modes [$];

    lock_order_monitor #(
        .STACK_DEPTH (STACK_N),
        .ID_BITS     (ID_W),
        .RANK_BITS   (RANK_W)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_func       (i_func),
        .i_lock_id    (i_lock_id),
        .i_lock_rank  (i_lock_rank),
        .i_hold_mode  (i_hold_mode),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_held_count (o_held_count),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report(input string what);
        $display("error at %0t: %s", $time, what);
        err_count++;
    endtask

    // result first: an answer can never belong to an item taken at the same edge
    always @(posedge i_clk) begin
        if (o_done === 1'b1) begin
            verdict = board.check_result(o_status, o_held_count);
            if (verdict != "")
                report(verdict);
        end
        if (i_rst_n && i_start && !o_busy)
            board.note_item('{fn: i_func, id: i_lock_id, rank: i_lock_rank,
                              mode: i_hold_mode});
    end

    // hang detector: any item taken or answer given restarts the count
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("lock_order_monitor: mismatch");
            $finish;
        end
    end

    // follow the stack as the stimulus sees it
    function automatic void track(t_lock_item it);
        int unsigned n;
        n = gen_ids.size();
        if (it.fn == lom_pkg::FN_PUSH && n < STACK_N) begin
            gen_ids.push_back(it.id);
            gen_ranks.push_back(it.rank);
            gen_modes.push_back(it.mode);
        end else if (it.fn == lom_pkg::FN_RELEASE && n > 0) begin
            if (gen_ids[n-1] == it.id && gen_modes[n-1] == it.mode) begin
                void'(gen_ids.pop_back());
                void'(gen_ranks.pop_back());
                void'(gen_modes.pop_back());
            end
        end
    endfunction

    // mostly well-formed lock traffic: ranks climb, releases match the top,
    // checks probe held identities and ranks around the held ones
    function automatic t_lock_item pick_item(int unsigned goal);
        t_lock_item        it;
        int unsigned       n;
        int unsigned       r;
        logic [RANK_W-1:0] top_rank;
        logic [RANK_W:0]   sum;
        n = gen_ids.size();
        top_rank = '0;
        foreach (gen_ranks[i])
            if (gen_ranks[i] > top_rank)
                top_rank = gen_ranks[i];
        it.id   = ID_W'($urandom);
        it.rank = RANK_W'($urandom);
        it.mode = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 4)
            it.fn = FN_IDLE;
        else if (r < 34)
            it.fn = lom_pkg::FN_CHECK;
        else if ((n < goal) ? (r < 79) : (r < 49))
            it.fn = lom_pkg::FN_PUSH;
        else
            it.fn = lom_pkg::FN_RELEASE;

        case (it.fn)
            lom_pkg::FN_PUSH: begin
                // duplicates are legal on push: the push is unchecked
                if (n > 0 && $urandom_range(0, 7) == 0)
                    it.id = gen_ids[$urandom_range(0, n-1)];
                case ($urandom_range(0, 7))
                    0: it.rank = '0;
                    1: ;
                    default: begin
                        sum = {1'b0, top_rank} + (RANK_W+1)'($urandom_range(1, 300));
                        it.rank = sum[RANK_W] ? '1 : sum[RANK_W-1:0];
                    end
                endcase
            end
            lom_pkg::FN_CHECK: begin
                if (n > 0 && $urandom_range(0, 3) == 0)
                    it.id = gen_ids[$urandom_range(0, n-1)];
                case ($urandom_range(0, 5))
                    0: it.rank = '0;
                    1: it.rank = '1;
                    2: it.rank = (top_rank == '1) ? top_rank : top_rank + 1'b1;
                    3: if (n > 0) it.rank = gen_ranks[$urandom_range(0, n-1)];
                    4: it.rank = top_rank - RANK_W'($urandom_range(0, 3));
                    default: ;
                endcase
            end
            lom_pkg::FN_RELEASE: begin
                if (n > 0) begin
                    it.id   = gen_ids[n-1];
                    it.mode = gen_modes[n-1];
                    // a few broken releases: wrong mode or wrong identity
                    case ($urandom_range(0, 9))
                        0: it.mode = ~it.mode;
                        1: it.id = (n > 1) ? gen_ids[$urandom_range(0, n-2)] : ~it.id;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        return it;
    endfunction

    // present one item, with random gaps before it, and hold until taken
    task automatic send_item(input t_lock_item it);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_start     <= 1'b0;
            i_func      <= 2'($urandom);
            i_lock_id   <= ID_W'($urandom);
            i_lock_rank <= RANK_W'($urandom);
            i_hold_mode <= 1'($urandom);
            @(posedge i_clk);
        end
        track(it);
        i_start     <= 1'b1;
        i_func      <= it.fn;
        i_lock_id   <= it.id;
        i_lock_rank <= it.rank;
        i_hold_mode <= it.mode;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
    endtask

    task automatic send(input logic [1:0] fn, input logic [ID_W-1:0] id,
                        input logic [RANK_W-1:0] rank, input logic mode);
        send_item('{fn: fn, id: id, rank: rank, mode: mode});
    endtask

    // stop sending and wait for every owed answer
    task automatic settle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0)
            @(posedge i_clk);
    endtask

    // limit register write, only with the block idle
    task automatic write_limit(input logic [lom_pkg::CFG_BITS-1:0] val);
        settle();
        repeat (STACK_N + 2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        board.set_limit(val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [lom_pkg::CFG_BITS-1:0] limit_seq [CHUNKS];
        int unsigned                  goal;
        int unsigned                  drain_at;

        board = new();
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_func      <= lom_pkg::FN_CHECK;
        i_lock_id   <= '0;
        i_lock_rank <= '0;
        i_hold_mode <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty release, unused func, all-ones fields
        send(lom_pkg::FN_RELEASE, '0, '0, 1'b0);
        send(FN_IDLE, '1, '1, 1'b1);
        send(lom_pkg::FN_CHECK, '0, '0, 1'b0);
        send(lom_pkg::FN_PUSH, '1, '1, 1'b1);
        // held identity, equal rank, unranked request
        send(lom_pkg::FN_CHECK, '1, '0, 1'b0);
        send(lom_pkg::FN_CHECK, '0, '1, 1'b0);
        send(lom_pkg::FN_CHECK, 32'd1, '0, 1'b0);
        // release with wrong mode, then wrong identity, then the right one
        send(lom_pkg::FN_RELEASE, '1, '0, 1'b0);
        send(lom_pkg::FN_RELEASE, 32'hFFFF_FFFE, '0, 1'b1);
        send(lom_pkg::FN_RELEASE, '1, '0, 1'b1);
        // ranked, unranked, ranked stack
        send(lom_pkg::FN_PUSH, 32'd5, 16'd10, 1'b0);
        send(lom_pkg::FN_PUSH, 32'd6, 16'd0, 1'b1);
        send(lom_pkg::FN_PUSH, 32'd7, 16'd20, 1'b0);
        // held found above a passing rank, order hit past an unranked entry,
        // identity wins over rank at the same entry, and a clean pass
        send(lom_pkg::FN_CHECK, 32'd6, 16'd30, 1'b0);
        send(lom_pkg::FN_CHECK, 32'd8, 16'd15, 1'b0);
        send(lom_pkg::FN_CHECK, 32'd5, 16'd5, 1'b0);
        send(lom_pkg::FN_CHECK, 32'd9, 16'd21, 1'b0);
        // limit equal to depth, limit of zero, push past the limit
        write_limit(5'd3);
        send(lom_pkg::FN_CHECK, 32'd9, 16'd21, 1'b0);
        write_limit(5'd0);
        send(lom_pkg::FN_CHECK, 32'd9, 16'd21, 1'b0);
        send(lom_pkg::FN_PUSH, 32'd10, 16'd30, 1'b1);
        // limit above the stack size: the check passes the limit test
        write_limit(5'd31);
        send(lom_pkg::FN_CHECK, 32'd11, 16'd40, 1'b0);
        send(FN_IDLE, '0, '0, 1'b0);

        // random part, one limit setting per chunk
        limit_seq = '{5'd16, 5'd1, 5'd31, 5'd8, 5'd0,
                      5'($urandom_range(2, 15)), 5'd15, 5'($urandom_range(0, 31))};
        goal = 0;
        for (int unsigned c = 0; c < CHUNKS; c++) begin
            write_limit(limit_seq[c]);
            // light sender gaps, then heavy, then none
            idle_pct = (c < 3) ? 15 : (c < 6) ? 72 : 0;
            drain_at = $urandom_range(20, CHUNK_ITEMS - 20);
            for (int unsigned k = 0; k < CHUNK_ITEMS; k++) begin
                // a new depth to aim for now and then; above the size means
                // pushes onto a full stack
                if (k % 40 == 0)
                    goal = ($urandom_range(0, 3) == 0) ? STACK_N + 1
                                                        : $urandom_range(0, STACK_N);
                if (k == drain_at)
                    settle();
                send_item(pick_item(goal));
            end
        end

        settle();
        repeat (STACK_N + 4) @(posedge i_clk);
        if (board.pending() != 0)
            report($sformatf("%0d answers never came", board.pending()));
        if (err_count == 0)
            $display("lock_order_monitor: match");
        else
            $display("lock_order_monitor: mismatch");
        $finish;
    end

endmodule
